// ===== sv/ipid_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipid_pkg
// Shared widths, register indexes and transaction types for the incremental
// PID controller.
// ----------------------------------------------------------------------------
package ipid_pkg;

  localparam int DATA_W      = 32;
  localparam int FRAC_BITS   = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // e1 - e and e - 2*e1 + e2
  localparam int DP_W  = DATA_W + 1;
  localparam int DD_W  = DATA_W + 3;
  localparam int PP_W  = DATA_W + DP_W;
  localparam int PI_W  = 2 * DATA_W;
  localparam int PD_W  = DATA_W + DD_W;
  localparam int SUM_W = PD_W + 2;

  localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT      = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P        = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I        = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D        = CFG_INDEX_W'(3);
  localparam logic [CFG_INDEX_W-1:0] REG_ERROR_FLOOR   = CFG_INDEX_W'(4);
  localparam logic [CFG_INDEX_W-1:0] REG_ERROR_CEILING = CFG_INDEX_W'(5);

  localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct packed {
    logic                   valid;
    logic [CFG_INDEX_W-1:0] index;
    logic [DATA_W-1:0]      data;
  } cfg_write_t;

  typedef struct packed {
    logic [DATA_W-1:0] err;
    logic [DATA_W-1:0] err_prev1;
    logic [DATA_W-1:0] err_prev2;
  } err_entry_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } queue_status_t;

endpackage
`default_nettype wire

// ===== sv/incremental_pid_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// incremental_pid_controller
// Velocity-form PID in Q16.16: one saturated control increment per sample.
// ----------------------------------------------------------------------------
// Takes one measured sample per clock while in_stall is low and returns one
// increment per sample, in order, through the queue, stages A, B and C and
// the output register. The sustained rate is one sample per cycle while
// out_stall is low, set by the product stage where the three gain multipliers
// run side by side. A four-entry queue between the error front end and the
// multiply pipeline absorbs output stalls before in_stall rises.
// Configuration writes are taken every cycle (cfg_ready is always high) and
// must be issued only while no sample is in flight; a setpoint write clears
// the error history.
module incremental_pid_controller (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ipid_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [ipid_pkg::DATA_W-1:0]            cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [ipid_pkg::DATA_W-1:0]     measured,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [ipid_pkg::DATA_W-1:0]     increment,
  output logic                                   saturated
);

  ipid_pkg::cfg_write_t    cfg;
  ipid_pkg::queue_status_t qstat;
  ipid_pkg::err_entry_t    push_entry;
  ipid_pkg::err_entry_t    pop_entry;
  logic                    push;
  logic                    pop;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  ipid_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .measured (measured),
    .qstat    (qstat),
    .push     (push),
    .entry    (push_entry)
  );

  ipid_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .qstat      (qstat)
  );

  ipid_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .qstat     (qstat),
    .entry     (pop_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .increment (increment),
    .saturated (saturated)
  );

`ifndef SYNTH
  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (increment == ipid_pkg::DATA_MAX) || (increment == ipid_pkg::DATA_MIN))
    else $error("saturated flag without a clipped increment");

  a_push_not_empty: assert property (@(posedge clk) disable iff (rst)
    push |=> !qstat.empty)
    else $error("queue empty after a push");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= ipid_pkg::QCNT_W'(ipid_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

// ===== sv/ipid_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipid_front
// Accepts measured samples, forms the clamped error and keeps the error
// history; pushes one error transaction per sample into the queue.
// ----------------------------------------------------------------------------
module ipid_front (
  input  logic                        clk,
  input  logic                        rst,
  input  ipid_pkg::cfg_write_t        cfg,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [ipid_pkg::DATA_W-1:0] measured,
  input  ipid_pkg::queue_status_t     qstat,
  output logic                        push,
  output ipid_pkg::err_entry_t        entry
);

  logic signed [ipid_pkg::DATA_W-1:0] setpoint;
  logic signed [ipid_pkg::DATA_W-1:0] error_floor;
  logic signed [ipid_pkg::DATA_W-1:0] error_ceiling;
  logic signed [ipid_pkg::DATA_W-1:0] err_prev1;
  logic signed [ipid_pkg::DATA_W-1:0] err_prev2;

  logic signed [ipid_pkg::DATA_W:0]   diff;
  logic signed [ipid_pkg::DATA_W:0]   floor_x;
  logic signed [ipid_pkg::DATA_W:0]   ceiling_x;
  logic signed [ipid_pkg::DATA_W-1:0] err;
  logic                               sp_write;

  assign in_stall = qstat.full;
  assign push     = in_valid && !qstat.full;
  assign sp_write = cfg.valid && (cfg.index == ipid_pkg::REG_SETPOINT);

  assign diff      = $signed({setpoint[ipid_pkg::DATA_W-1], setpoint})
                   - $signed({measured[ipid_pkg::DATA_W-1], measured});
  assign floor_x   = $signed({error_floor[ipid_pkg::DATA_W-1], error_floor});
  assign ceiling_x = $signed({error_ceiling[ipid_pkg::DATA_W-1], error_ceiling});

  // floor test wins when floor is above ceiling
  always_comb begin
    priority if (diff < floor_x) begin
      err = error_floor;
    end else if (diff > ceiling_x) begin
      err = error_ceiling;
    end else begin
      err = diff[ipid_pkg::DATA_W-1:0];
    end
  end

  assign entry.err       = err;
  assign entry.err_prev1 = err_prev1;
  assign entry.err_prev2 = err_prev2;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint      <= '0;
      error_floor   <= ipid_pkg::DATA_MIN;
      error_ceiling <= ipid_pkg::DATA_MAX;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ipid_pkg::REG_SETPOINT:      setpoint      <= cfg.data;
        ipid_pkg::REG_ERROR_FLOOR:   error_floor   <= cfg.data;
        ipid_pkg::REG_ERROR_CEILING: error_ceiling <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || sp_write) begin
      err_prev1 <= '0;
      err_prev2 <= '0;
    end else if (push) begin
      err_prev1 <= err;
      err_prev2 <= err_prev1;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ipid_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipid_queue
// Short FIFO of error transactions between the front and back parts.
// ----------------------------------------------------------------------------
module ipid_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  ipid_pkg::err_entry_t    push_entry,
  input  logic                    pop,
  output ipid_pkg::err_entry_t    pop_entry,
  output ipid_pkg::queue_status_t qstat
);

  ipid_pkg::err_entry_t              slots [ipid_pkg::QUEUE_DEPTH];
  logic [ipid_pkg::QPTR_W-1:0]       wr_ptr;
  logic [ipid_pkg::QPTR_W-1:0]       rd_ptr;
  logic [ipid_pkg::QCNT_W-1:0]       count;
  logic [ipid_pkg::QCNT_W-1:0]       count_next;

  localparam logic [ipid_pkg::QPTR_W-1:0] LAST_PTR =
    ipid_pkg::QPTR_W'(ipid_pkg::QUEUE_DEPTH - 1);

  assign qstat.count = count;
  assign qstat.full  = (count == ipid_pkg::QCNT_W'(ipid_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign pop_entry   = slots[rd_ptr];

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/ipid_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipid_back
// Execution pipeline: error differences, three gain products, sum with
// fixed-point rescale, saturation into the output register.
// ----------------------------------------------------------------------------
module ipid_back (
  input  logic                                clk,
  input  logic                                rst,
  input  ipid_pkg::cfg_write_t                cfg,
  input  ipid_pkg::queue_status_t             qstat,
  input  ipid_pkg::err_entry_t                entry,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ipid_pkg::DATA_W-1:0]  increment,
  output logic                                saturated
);

  localparam int DW = ipid_pkg::DATA_W;
  localparam int XW = ipid_pkg::DD_W - DW;

  logic signed [DW-1:0] gain_p;
  logic signed [DW-1:0] gain_i;
  logic signed [DW-1:0] gain_d;

  logic                 advance;

  // stage A
  logic                                va;
  logic signed [ipid_pkg::DP_W-1:0]    dp;
  logic signed [ipid_pkg::DD_W-1:0]    dd;
  logic signed [DW-1:0]                ea;
  logic signed [ipid_pkg::DD_W-1:0]    e_dd;
  logic signed [ipid_pkg::DD_W-1:0]    e1_dd;
  logic signed [ipid_pkg::DD_W-1:0]    e2_dd;

  // stage B
  logic                                vb;
  logic signed [ipid_pkg::PP_W-1:0]    prod_p;
  logic signed [ipid_pkg::PI_W-1:0]    prod_i;
  logic signed [ipid_pkg::PD_W-1:0]    prod_d;

  // stage C
  logic                                vc;
  logic signed [ipid_pkg::SUM_W-1:0]   sum;

  logic signed [ipid_pkg::SUM_W-1:0]   shifted;
  logic [ipid_pkg::SUM_W-DW:0]         upper;
  logic signed [DW-1:0]                inc_next;
  logic                                sat_next;

  assign advance = !out_valid || !out_stall;
  assign pop     = advance && !qstat.empty;

  assign e_dd  = $signed({{XW{entry.err[DW-1]}}, entry.err});
  assign e1_dd = $signed({{XW{entry.err_prev1[DW-1]}}, entry.err_prev1});
  assign e2_dd = $signed({{XW{entry.err_prev2[DW-1]}}, entry.err_prev2});

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= '0;
      gain_i <= '0;
      gain_d <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ipid_pkg::REG_GAIN_P: gain_p <= cfg.data;
        ipid_pkg::REG_GAIN_I: gain_i <= cfg.data;
        ipid_pkg::REG_GAIN_D: gain_d <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      va        <= !qstat.empty;
      vb        <= va;
      vc        <= vb;
      out_valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dp     <= $signed({entry.err_prev1[DW-1], entry.err_prev1})
              - $signed({entry.err[DW-1], entry.err});
      dd     <= e_dd - (e1_dd <<< 1) + e2_dd;
      ea     <= entry.err;

      prod_p <= gain_p * dp;
      prod_i <= gain_i * ea;
      prod_d <= gain_d * dd;

      sum    <= $signed({{(ipid_pkg::SUM_W-ipid_pkg::PP_W){prod_p[ipid_pkg::PP_W-1]}},
                         prod_p})
              + $signed({{(ipid_pkg::SUM_W-ipid_pkg::PI_W){prod_i[ipid_pkg::PI_W-1]}},
                         prod_i})
              + $signed({{(ipid_pkg::SUM_W-ipid_pkg::PD_W){prod_d[ipid_pkg::PD_W-1]}},
                         prod_d});

      increment <= inc_next;
      saturated <= sat_next;
    end
  end

  assign shifted = sum >>> ipid_pkg::FRAC_BITS;
  assign upper   = shifted[ipid_pkg::SUM_W-1:DW-1];

  always_comb begin
    priority if ((&upper) || !(|upper)) begin
      inc_next = shifted[DW-1:0];
      sat_next = 1'b0;
    end else if (upper[ipid_pkg::SUM_W-DW]) begin
      inc_next = ipid_pkg::DATA_MIN;
      sat_next = 1'b1;
    end else begin
      inc_next = ipid_pkg::DATA_MAX;
      sat_next = 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== test/tb_incremental_pid_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_incremental_pid_controller
// Self-checking bench for the velocity-form Q16.16 PID controller.
// ----------------------------------------------------------------------------
// A directed table covers reset gains, error clamps at both ends, floor above
// ceiling, output saturation both ways, unmapped register writes and history
// clearing on setpoint writes. Random phases then reprogram every register
// and stream samples under different source-idle and sink-stall mixes. Each
// increment is checked against a table literal or the bench's bit-accurate predictor.
// ----------------------------------------------------------------------------
module tb_incremental_pid_controller;

  localparam logic [ipid_pkg::CFG_INDEX_W-1:0] REG_UNUSED_6 = ipid_pkg::CFG_INDEX_W'(6);
  localparam logic [ipid_pkg::CFG_INDEX_W-1:0] REG_UNUSED_7 = ipid_pkg::CFG_INDEX_W'(7);
  localparam longint INC_HI = 64'sd2147483647;
  localparam longint INC_LO = -64'sd2147483648;
  localparam int NUM_PHASES = 12;
  localparam int SAMPLES_PER_PHASE = 86;
  localparam int NUM_ROWS = 34;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_SAMPLE,
    ROW_CHECKED
  } row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic [ipid_pkg::CFG_INDEX_W-1:0] index;
    logic [ipid_pkg::DATA_W-1:0]      value;
    logic [ipid_pkg::DATA_W-1:0]      lit_increment;
    logic                             lit_saturated;
  } dir_row_t;

  typedef struct packed {
    logic [ipid_pkg::DATA_W-1:0] increment;
    logic                        saturated;
  } pid_result_t;

  logic                               clk = 1'b0;
  logic                               rst;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [ipid_pkg::CFG_INDEX_W-1:0]   cfg_index;
  logic [ipid_pkg::DATA_W-1:0]        cfg_data;
  logic                               in_valid;
  logic                               in_stall;
  logic signed [ipid_pkg::DATA_W-1:0] measured;
  logic                               out_valid;
  logic                               out_stall;
  logic signed [ipid_pkg::DATA_W-1:0] increment;
  logic                               saturated;

  // predictor state
  logic signed [ipid_pkg::DATA_W-1:0] ctl_setpoint  = '0;
  logic signed [ipid_pkg::DATA_W-1:0] ctl_gain_p    = '0;
  logic signed [ipid_pkg::DATA_W-1:0] ctl_gain_i    = '0;
  logic signed [ipid_pkg::DATA_W-1:0] ctl_gain_d    = '0;
  logic signed [ipid_pkg::DATA_W-1:0] ctl_err_floor = ipid_pkg::DATA_MIN;
  logic signed [ipid_pkg::DATA_W-1:0] ctl_err_ceil  = ipid_pkg::DATA_MAX;
  logic signed [ipid_pkg::DATA_W-1:0] hist_e1       = '0;
  logic signed [ipid_pkg::DATA_W-1:0] hist_e2       = '0;

  pid_result_t pending_results[$];
  pid_result_t got_result;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int          error_count    = 0;

  int unsigned idle_by_mode[4]  = '{0, 65, 0, 27};
  int unsigned stall_by_mode[4] = '{0, 0, 65, 27};

  dir_row_t dir_rows[NUM_ROWS] = '{
    '{ROW_CHECKED, '0, 32'h0000_0000, 32'h0000_0000, 1'b0},
    '{ROW_CHECKED, '0, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0},
    '{ROW_CHECKED, '0, 32'h8000_0000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE, ipid_pkg::REG_GAIN_I, 32'h0001_0000, '0, 1'b0},
    '{ROW_CHECKED, '0, 32'hFFFF_0000, 32'h0001_0000, 1'b0},
    '{ROW_CHECKED, '0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0},
    '{ROW_CHECKED, '0, 32'h7FFF_FFFF, 32'h8000_0001, 1'b0},
    '{ROW_WRITE, ipid_pkg::REG_GAIN_I, 32'h7FFF_FFFF, '0, 1'b0},
    '{ROW_CHECKED, '0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1},
    '{ROW_CHECKED, '0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1},
    '{ROW_WRITE, ipid_pkg::REG_GAIN_I, 32'h8000_0000, '0, 1'b0},
    '{ROW_CHECKED, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1},
    '{ROW_WRITE, ipid_pkg::REG_GAIN_P, 32'h0001_8000, '0, 1'b0},
    '{ROW_WRITE, ipid_pkg::REG_GAIN_D, 32'hFFFF_4000, '0, 1'b0},
    '{ROW_WRITE, ipid_pkg::REG_GAIN_I, 32'h0000_2000, '0, 1'b0},
    '{ROW_SAMPLE, '0, 32'h0003_0000, '0, 1'b0},
    '{ROW_SAMPLE, '0, 32'hFFFD_0000, '0, 1'b0},
    '{ROW_SAMPLE, '0, 32'h0000_0000, '0, 1'b0},
    '{ROW_WRITE, ipid_pkg::REG_SETPOINT, 32'h0005_0000, '0, 1'b0},
    '{ROW_SAMPLE, '0, 32'h0005_0000, '0, 1'b0},
    '{ROW_SAMPLE, '0, 32'h0004_8000, '0, 1'b0},
    // floor above ceiling
    '{ROW_WRITE, ipid_pkg::REG_ERROR_FLOOR, 32'h0001_0000, '0, 1'b0},
    '{ROW_WRITE, ipid_pkg::REG_ERROR_CEILING, 32'hFFFF_0000, '0, 1'b0},
    '{ROW_SAMPLE, '0, 32'h8000_0000, '0, 1'b0},
    '{ROW_SAMPLE, '0, 32'h7FFF_FFFF, '0, 1'b0},
    // unmapped indexes leave history alone
    '{ROW_WRITE, REG_UNUSED_6, 32'h1234_5678, '0, 1'b0},
    '{ROW_WRITE, REG_UNUSED_7, 32'hFFFF_FFFF, '0, 1'b0},
    '{ROW_SAMPLE, '0, 32'h0005_0000, '0, 1'b0},
    // raw error beyond 32 bits
    '{ROW_WRITE, ipid_pkg::REG_SETPOINT, 32'h8000_0000, '0, 1'b0},
    '{ROW_WRITE, ipid_pkg::REG_ERROR_FLOOR, 32'h8000_0000, '0, 1'b0},
    '{ROW_WRITE, ipid_pkg::REG_ERROR_CEILING, 32'h7FFF_FFFF, '0, 1'b0},
    '{ROW_SAMPLE, '0, 32'h7FFF_FFFF, '0, 1'b0},
    '{ROW_WRITE, ipid_pkg::REG_SETPOINT, 32'h7FFF_FFFF, '0, 1'b0},
    '{ROW_SAMPLE, '0, 32'h8000_0000, '0, 1'b0}
  };

  incremental_pid_controller u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .measured  (measured),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .increment (increment),
    .saturated (saturated)
  );

  always #5 clk = ~clk;

  function automatic pid_result_t predict_increment(
    input logic signed [ipid_pkg::DATA_W-1:0] m
  );
    logic signed [ipid_pkg::DATA_W:0]   err_raw;
    logic signed [ipid_pkg::DATA_W-1:0] err;
    logic signed [127:0]                acc;
    pid_result_t                        r;
    err_raw = ctl_setpoint - m;
    if (err_raw < ctl_err_floor) begin
      err = ctl_err_floor;
    end else if (err_raw > ctl_err_ceil) begin
      err = ctl_err_ceil;
    end else begin
      err = err_raw[ipid_pkg::DATA_W-1:0];
    end
    acc = ctl_gain_p * (hist_e1 - err) + ctl_gain_i * err
        + ctl_gain_d * (err - 2 * hist_e1 + hist_e2);
    acc = acc >>> ipid_pkg::FRAC_BITS;
    if (acc > INC_HI) begin
      r = '{ipid_pkg::DATA_MAX, 1'b1};
    end else if (acc < INC_LO) begin
      r = '{ipid_pkg::DATA_MIN, 1'b1};
    end else begin
      r = '{acc[ipid_pkg::DATA_W-1:0], 1'b0};
    end
    hist_e2 = hist_e1;
    hist_e1 = err;
    return r;
  endfunction

  function automatic void mirror_register(input logic [ipid_pkg::CFG_INDEX_W-1:0] idx,
                                          input logic [ipid_pkg::DATA_W-1:0] val);
    case (idx)
      ipid_pkg::REG_SETPOINT: begin
        ctl_setpoint = val;
        hist_e1 = '0;
        hist_e2 = '0;
      end
      ipid_pkg::REG_GAIN_P:        ctl_gain_p = val;
      ipid_pkg::REG_GAIN_I:        ctl_gain_i = val;
      ipid_pkg::REG_GAIN_D:        ctl_gain_d = val;
      ipid_pkg::REG_ERROR_FLOOR:   ctl_err_floor = val;
      ipid_pkg::REG_ERROR_CEILING: ctl_err_ceil = val;
      default: ;
    endcase
  endfunction

  function automatic logic [ipid_pkg::DATA_W-1:0] pick_gain();
    logic [ipid_pkg::DATA_W-1:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0: return ipid_pkg::DATA_MAX;
      1: return ipid_pkg::DATA_MIN;
      2: return '0;
      3: return r;
      default: return {{12{r[19]}}, r[19:0]};
    endcase
  endfunction

  function automatic logic [ipid_pkg::DATA_W-1:0] pick_sample();
    logic [ipid_pkg::DATA_W-1:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0: return ipid_pkg::DATA_MIN;
      1: return ipid_pkg::DATA_MAX;
      2, 3: return r;
      default: return ctl_setpoint + {{14{r[17]}}, r[17:0]};
    endcase
  endfunction

  // config writes only once nothing is in flight
  task automatic write_register(input logic [ipid_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [ipid_pkg::DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    mirror_register(idx, val);
  endtask

  task automatic send_sample(input logic [ipid_pkg::DATA_W-1:0] m);
    cfg_valid <= 1'b0;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    measured <= m;
    do @(posedge clk); while (in_stall);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected transaction: increment %h saturated %b", increment, saturated);
          error_count++;
        end else begin
          got_result = pending_results.pop_front();
          if (increment !== got_result.increment) begin
            $error("increment mismatch: expected %h, actual %h",
                   got_result.increment, increment);
            error_count++;
          end
          if (saturated !== got_result.saturated) begin
            $error("saturated mismatch: expected %b, actual %b",
                   got_result.saturated, saturated);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [ipid_pkg::DATA_W-1:0] lim;
    logic [ipid_pkg::DATA_W-1:0] r;
    pid_result_t                 exp_result;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    measured  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        write_register(dir_rows[i].index, dir_rows[i].value);
      end else begin
        exp_result = predict_increment(dir_rows[i].value);
        if (dir_rows[i].kind == ROW_CHECKED)
          exp_result = '{dir_rows[i].lit_increment, dir_rows[i].lit_saturated};
        pending_results.push_back(exp_result);
        send_sample(dir_rows[i].value);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 0 || $urandom_range(1) == 1) begin
        r = $urandom;
        case ($urandom_range(4))
          0: write_register(ipid_pkg::REG_SETPOINT, ipid_pkg::DATA_MIN);
          1: write_register(ipid_pkg::REG_SETPOINT, ipid_pkg::DATA_MAX);
          2: write_register(ipid_pkg::REG_SETPOINT, r);
          default: write_register(ipid_pkg::REG_SETPOINT, {{8{r[23]}}, r[23:0]});
        endcase
      end
      write_register(ipid_pkg::REG_GAIN_P, pick_gain());
      write_register(ipid_pkg::REG_GAIN_I, pick_gain());
      write_register(ipid_pkg::REG_GAIN_D, pick_gain());
      lim = $urandom_range(1, 32'h0004_0000);
      case ($urandom_range(4))
        0: begin
          write_register(ipid_pkg::REG_ERROR_FLOOR, ipid_pkg::DATA_MIN);
          write_register(ipid_pkg::REG_ERROR_CEILING, ipid_pkg::DATA_MAX);
        end
        1: begin
          write_register(ipid_pkg::REG_ERROR_FLOOR, lim);
          write_register(ipid_pkg::REG_ERROR_CEILING, -lim);
        end
        2: begin
          write_register(ipid_pkg::REG_ERROR_FLOOR, $urandom);
          write_register(ipid_pkg::REG_ERROR_CEILING, $urandom);
        end
        default: begin
          write_register(ipid_pkg::REG_ERROR_FLOOR, -lim);
          write_register(ipid_pkg::REG_ERROR_CEILING, lim);
        end
      endcase
      if ($urandom_range(3) == 0)
        write_register($urandom_range(1) ? REG_UNUSED_6 : REG_UNUSED_7, $urandom);

      src_idle_pct   = idle_by_mode[phase % 4];
      sink_stall_pct = stall_by_mode[phase % 4];
      for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
        r = pick_sample();
        pending_results.push_back(predict_increment(r));
        send_sample(r);
      end
    end

    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
sv/ipid_pkg.sv
sv/ipid_front.sv
sv/ipid_queue.sv
sv/ipid_back.sv
sv/incremental_pid_controller.sv
test/tb_incremental_pid_controller.sv
